/* src/imhq_pkg.sv */
// Package: types and codes shared by the indexed min-heap queue.
package imhq_pkg;

  localparam int unsigned KEY_W = 9;
  localparam int unsigned PRIO_FIELD_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               command;
    logic [KEY_W-1:0]         key;
    logic signed [PRIO_FIELD_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]         entry_count;
    logic [KEY_W-1:0]         top_key;
    logic signed [PRIO_FIELD_W-1:0] top_prio;
    logic                     key_held;
    logic [1:0]               status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_RD_POS,
    S_PUSH_WR,
    S_POP_RD_LAST,
    S_POP_MOVE,
    S_UPD_WR,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD_L,
    S_DN_RD_R,
    S_DN_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_TOP_RD,
    S_HELD_RD,
    S_DONE
  } state_t;

endpackage

/* src/imhq_ram.sv */
// Generic single-port RAM with registered read.
module imhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/indexed_min_heap_queue.sv */
// Indexed binary min-heap queue: one item per command, one result per item.
// A query or a rejected item passes through lookup, decide, top read and held read to the
// result; a change to the heap adds set-up states and then sifts up or down, level by level.
// Items are taken one at a time: the next is taken only once the result has left
// and the block is back in its idle state.
// Reset: clears the count and sweeps the key-to-position map, one entry a
// cycle, through all KEY_COUNT entries, before the first item is taken.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 256,
  parameter int unsigned PRIORITY_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned AW = $clog2(KEY_COUNT);
  localparam int unsigned PW = $clog2(KEY_COUNT + 1);
  localparam int unsigned PRW = PRIORITY_WIDTH;

  state_t state, state_next;

  // request registers
  cmd_t             cmd;
  logic [KEY_W-1:0] key;
  logic [PRW-1:0]   pr;

  logic [PW-1:0]    fill;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    oth;
  logic [PW-1:0]    best;
  logic [PRW-1:0]   cur_p;
  logic [AW-1:0]    cur_k;
  logic [PRW-1:0]   oth_p;
  logic [AW-1:0]    oth_k;
  logic [PRW-1:0]   gone_p;
  logic             up_mode;
  logic [1:0]       status;
  logic             key_held;
  logic [PW-1:0]    top_key_r;
  logic [PRW-1:0]   top_p_r;
  logic             clearing;
  logic [PW-1:0]    clr_cnt;

  // memories
  logic             sk_we, sp_we, kp_we;
  logic [AW-1:0]    sk_a, sp_a, kp_a;
  logic [AW-1:0]    sk_wd, sk_rd;
  logic [PRW-1:0]   sp_wd, sp_rd;
  logic [PW-1:0]    kp_wd, kp_rd;

  imhq_ram #(.WIDTH(AW), .DEPTH(KEY_COUNT)) u_slot_key (
    .clk(clk), .we(sk_we), .addr(sk_a), .wdata(sk_wd), .rdata(sk_rd));
  imhq_ram #(.WIDTH(PRW), .DEPTH(KEY_COUNT)) u_slot_prio (
    .clk(clk), .we(sp_we), .addr(sp_a), .wdata(sp_wd), .rdata(sp_rd));
  imhq_ram #(.WIDTH(PW), .DEPTH(KEY_COUNT)) u_key_pos (
    .clk(clk), .we(kp_we), .addr(kp_a), .wdata(kp_wd), .rdata(kp_rd));

  function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = p - PW'(1);
    return q[AW-1:0];
  endfunction

  function automatic logic less(input logic [PRW-1:0] a, input logic [PRW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  logic key_ok;
  logic [AW-1:0] key_idx;
  logic [KEY_W-1:0] key_m1;
  logic [PRW-1:0] pr_in;

  assign key_ok  = (key != '0) && ({{(32-KEY_W){1'b0}}, key} <= 32'(KEY_COUNT));
  assign key_m1  = key - KEY_W'(1);
  assign key_idx = AW'(key_m1);

  always_comb begin
    logic [PRW+31:0] ext;
    ext   = {{PRW{in_item.priority_req[PRIO_FIELD_W-1]}}, in_item.priority_req};
    pr_in = ext[PRW-1:0];
  end

  logic [PW:0] lchild, rchild;
  assign lchild = {pos, 1'b0};
  assign rchild = {pos, 1'b1};

  // local next values
  logic [PW-1:0]  fill_next, pos_next, oth_next, best_next;
  logic [PRW-1:0] cur_p_next, oth_p_next, gone_p_next;
  logic [AW-1:0]  cur_k_next, oth_k_next;
  logic           up_mode_next, key_held_next;
  logic [1:0]     status_next;
  logic [PW-1:0]  top_key_next;
  logic [PRW-1:0] top_p_next;

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    pos_next      = pos;
    oth_next      = oth;
    best_next     = best;
    cur_p_next    = cur_p;
    cur_k_next    = cur_k;
    oth_p_next    = oth_p;
    oth_k_next    = oth_k;
    gone_p_next   = gone_p;
    up_mode_next  = up_mode;
    status_next   = status;
    key_held_next = key_held;
    top_key_next  = top_key_r;
    top_p_next    = top_p_r;
    sk_we = 1'b0; sp_we = 1'b0; kp_we = 1'b0;
    sk_a  = '0;   sp_a  = '0;   kp_a  = key_idx;
    sk_wd = cur_k; sp_wd = cur_p; kp_wd = '0;
    unique case (state)
      S_IDLE: begin
        if (clearing) begin
          kp_we = 1'b1;
          kp_a  = clr_cnt[AW-1:0];
        end
      end
      S_LOOKUP: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        status_next = ST_OK;
        if (cmd == CMD_POP) begin
          if (fill == '0) begin
            status_next = ST_EMPTY;
            state_next  = S_TOP_RD;
          end else if (key == '0) begin
            pos_next   = PW'(1);
            state_next = S_RD_POS;
          end else if (!key_ok) begin
            status_next = ST_RANGE;
            state_next  = S_TOP_RD;
          end else if (kp_rd == '0) begin
            status_next = ST_ABSENT;
            state_next  = S_TOP_RD;
          end else begin
            pos_next   = kp_rd;
            state_next = S_RD_POS;
          end
        end else if (!key_ok) begin
          status_next = ST_RANGE;
          state_next  = S_TOP_RD;
        end else if (cmd == CMD_PUSH) begin
          if (kp_rd != '0) begin
            pos_next   = kp_rd;
            state_next = S_RD_POS;
          end else if (fill < PW'(KEY_COUNT)) begin
            fill_next  = fill + PW'(1);
            pos_next   = fill + PW'(1);
            cur_k_next = key_idx;
            cur_p_next = pr;
            state_next = S_PUSH_WR;
          end else begin
            state_next = S_TOP_RD;
          end
        end else begin
          state_next = S_TOP_RD;
        end
      end
      S_RD_POS: begin
        sk_a = slot_addr(pos);
        sp_a = slot_addr(pos);
        state_next = (cmd == CMD_POP) ? S_POP_RD_LAST : S_UPD_WR;
      end
      S_PUSH_WR: begin
        sk_we = 1'b1; sk_a = slot_addr(pos);
        sp_we = 1'b1; sp_a = slot_addr(pos);
        kp_we = 1'b1; kp_a = cur_k; kp_wd = pos;
        state_next = S_UP_RD;
      end
      S_UPD_WR: begin
        cur_k_next = sk_rd;
        cur_p_next = pr;
        sp_we = 1'b1; sp_a = slot_addr(pos); sp_wd = pr;
        if (less(sp_rd, pr)) begin
          state_next = S_DN_RD_L;
        end else if (less(pr, sp_rd)) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_TOP_RD;
        end
      end
      S_POP_RD_LAST: begin
        gone_p_next = sp_rd;
        kp_we = 1'b1; kp_a = sk_rd; kp_wd = '0;
        sk_a = slot_addr(fill);
        sp_a = slot_addr(fill);
        state_next = S_POP_MOVE;
      end
      S_POP_MOVE: begin
        fill_next = fill - PW'(1);
        if (pos == fill) begin
          state_next = S_TOP_RD;
        end else begin
          cur_k_next = sk_rd;
          cur_p_next = sp_rd;
          sk_we = 1'b1; sk_a = slot_addr(pos); sk_wd = sk_rd;
          sp_we = 1'b1; sp_a = slot_addr(pos); sp_wd = sp_rd;
          kp_we = 1'b1; kp_a = sk_rd; kp_wd = pos;
          if (less(gone_p, sp_rd)) begin
            state_next = S_DN_RD_L;
          end else if (less(sp_rd, gone_p)) begin
            state_next = S_UP_RD;
          end else begin
            state_next = S_TOP_RD;
          end
        end
      end
      S_UP_RD: begin
        up_mode_next = 1'b1;
        if (pos <= PW'(1)) begin
          state_next = S_TOP_RD;
        end else begin
          oth_next = pos >> 1;
          sk_a = slot_addr(pos >> 1);
          sp_a = slot_addr(pos >> 1);
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (less(cur_p, sp_rd)) begin
          oth_k_next = sk_rd;
          oth_p_next = sp_rd;
          state_next = S_SWAP_A;
        end else begin
          state_next = S_TOP_RD;
        end
      end
      S_DN_RD_L: begin
        up_mode_next = 1'b0;
        if (lchild > {1'b0, fill}) begin
          state_next = S_TOP_RD;
        end else begin
          sk_a = slot_addr(lchild[PW-1:0]);
          sp_a = slot_addr(lchild[PW-1:0]);
          state_next = S_DN_RD_R;
        end
      end
      S_DN_RD_R: begin
        oth_k_next = sk_rd;
        oth_p_next = sp_rd;
        oth_next   = lchild[PW-1:0];
        if (rchild > {1'b0, fill}) begin
          state_next = S_DN_CMP;
        end else begin
          sk_a = slot_addr(rchild[PW-1:0]);
          sp_a = slot_addr(rchild[PW-1:0]);
          best_next  = rchild[PW-1:0];
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (rchild <= {1'b0, fill} && best == rchild[PW-1:0] && less(sp_rd, oth_p)) begin
          if (less(sp_rd, cur_p)) begin
            oth_k_next = sk_rd;
            oth_p_next = sp_rd;
            oth_next   = rchild[PW-1:0];
            state_next = S_SWAP_A;
          end else begin
            state_next = S_TOP_RD;
          end
        end else if (less(oth_p, cur_p)) begin
          state_next = S_SWAP_A;
        end else begin
          state_next = S_TOP_RD;
        end
        best_next = '0;
      end
      S_SWAP_A: begin
        // move the other entry into the current slot
        sk_we = 1'b1; sk_a = slot_addr(pos); sk_wd = oth_k;
        sp_we = 1'b1; sp_a = slot_addr(pos); sp_wd = oth_p;
        kp_we = 1'b1; kp_a = oth_k; kp_wd = pos;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        sk_we = 1'b1; sk_a = slot_addr(oth);
        sp_we = 1'b1; sp_a = slot_addr(oth);
        kp_we = 1'b1; kp_a = cur_k; kp_wd = oth;
        pos_next   = oth;
        state_next = up_mode ? S_UP_RD : S_DN_RD_L;
      end
      S_TOP_RD: begin
        sk_a = '0;
        sp_a = '0;
        kp_a = key_idx;
        state_next = S_HELD_RD;
      end
      S_HELD_RD: begin
        top_key_next  = (fill == '0) ? '0 : PW'(sk_rd) + PW'(1);
        top_p_next    = (fill == '0) ? '0 : sp_rd;
        key_held_next = key_ok && (kp_rd != '0);
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_IDLE && !clearing && in_valid) begin
      state_next = S_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + PW'(1);
        if (clr_cnt == PW'(KEY_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && !clearing && in_valid) begin
      cmd <= cmd_t'(in_item.command);
      key <= in_item.key;
      pr  <= pr_in;
    end
    pos       <= pos_next;
    oth       <= oth_next;
    best      <= best_next;
    cur_p     <= cur_p_next;
    cur_k     <= cur_k_next;
    oth_p     <= oth_p_next;
    oth_k     <= oth_k_next;
    gone_p    <= gone_p_next;
    up_mode   <= up_mode_next;
    status    <= status_next;
    key_held  <= key_held_next;
    top_key_r <= top_key_next;
    top_p_r   <= top_p_next;
  end

  logic [31:0] top_p32;
  always_comb begin
    logic [PRW+31:0] ext;
    ext     = {{32{top_p_r[PRW-1]}}, top_p_r};
    top_p32 = ext[31:0];
  end

  assign in_stall  = (state != S_IDLE) || clearing;
  assign out_valid = (state == S_DONE);
  assign out_item.entry_count  = KEY_W'(fill);
  assign out_item.top_key      = KEY_W'(top_key_r);
  assign out_item.top_prio     = top_p32;
  assign out_item.key_held     = key_held;
  assign out_item.status       = status;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PW'(KEY_COUNT)) else $error("entry count beyond capacity");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall) else $error("item taken during map sweep");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (fill == $past(fill))) else $error("count moved while idle");
  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.entry_count == '0) |-> (out_item.top_key == '0))
    else $error("top key on empty heap");

endmodule

/* test/tb_top.sv */
// Testbench for the indexed min-heap queue: random and directed items checked against a heap model.
module tb_top;
  import imhq_pkg::*;

  localparam int KEYS = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  indexed_min_heap_queue i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // heap model, positions from 1
  logic [8:0] heap_key [1:KEYS];
  logic signed [31:0] heap_prio [1:KEYS];
  int key_pos [1:KEYS];
  int heap_size;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_off_cycles = 0;
  int mismatch_count = 0;
  bit stimulus_done = 1'b0;

  function automatic void swap_entries(int p, int q);
    logic [8:0] k;
    logic signed [31:0] v;
    k = heap_key[p]; heap_key[p] = heap_key[q]; heap_key[q] = k;
    v = heap_prio[p]; heap_prio[p] = heap_prio[q]; heap_prio[q] = v;
    key_pos[heap_key[p]] = p;
    key_pos[heap_key[q]] = q;
  endfunction

  function automatic void sift_up(int pos);
    while (pos > 1 && heap_prio[pos] < heap_prio[pos/2]) begin
      swap_entries(pos, pos/2);
      pos = pos/2;
    end
  endfunction

  function automatic void sift_down(int pos);
    int l;
    int b;
    while (2*pos <= heap_size) begin
      l = 2*pos;
      b = l;
      if (l+1 <= heap_size && heap_prio[l+1] < heap_prio[l]) b = l+1;
      if (!(heap_prio[b] < heap_prio[pos])) break;
      swap_entries(pos, b);
      pos = b;
    end
  endfunction

  function automatic void reorder(int pos, logic signed [31:0] old_p, logic signed [31:0] new_p);
    if (old_p < new_p) sift_down(pos);
    else if (new_p < old_p) sift_up(pos);
  endfunction

  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t r;
    int k;
    int pos;
    int last;
    logic signed [31:0] old_p;
    status_t st;
    bit key_valid;
    k = it.key;
    key_valid = (k >= 1 && k <= KEYS);
    st = ST_OK;
    if (cmd_t'(it.command) == CMD_POP) begin
      if (heap_size == 0) st = ST_EMPTY;
      else if (k != 0 && !key_valid) st = ST_RANGE;
      else if (k != 0 && key_pos[k] == 0) st = ST_ABSENT;
      else begin
        pos = (k == 0) ? 1 : key_pos[k];
        last = heap_size;
        old_p = heap_prio[pos];
        key_pos[heap_key[pos]] = 0;
        if (pos != last) begin
          heap_key[pos] = heap_key[last];
          heap_prio[pos] = heap_prio[last];
          key_pos[heap_key[pos]] = pos;
        end
        heap_size = last - 1;
        if (pos != last) reorder(pos, old_p, heap_prio[pos]);
      end
    end else if (!key_valid) begin
      st = ST_RANGE;
    end else if (cmd_t'(it.command) == CMD_PUSH) begin
      pos = key_pos[k];
      if (pos != 0) begin
        old_p = heap_prio[pos];
        heap_prio[pos] = it.priority_req;
        reorder(pos, old_p, it.priority_req);
      end else if (heap_size < KEYS) begin
        heap_size++;
        heap_key[heap_size] = 9'(k);
        heap_prio[heap_size] = it.priority_req;
        key_pos[k] = heap_size;
        sift_up(heap_size);
      end
    end
    r.entry_count = 9'(heap_size);
    r.top_key = heap_size ? heap_key[1] : '0;
    r.top_prio = heap_size ? heap_prio[1] : '0;
    r.key_held = key_valid && key_pos[k] != 0;
    r.status = st;
    return r;
  endfunction

  function automatic in_item_t make_item(cmd_t c, int k, logic [31:0] p);
    in_item_t it;
    it.command = c;
    it.key = 9'(k);
    it.priority_req = p;
    return it;
  endfunction

  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15) - 8;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item(int key_span);
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(1, key_span);
    if (r < 3) return make_item(cmd_t'($urandom_range(0, 3)), $urandom_range(257, 511), $urandom);
    if (r < 6) return make_item(CMD_SPARE, k, $urandom);
    if (r < 10) return make_item(CMD_QUERY, $urandom_range(0, 1) ? k : 0, $urandom);
    if (r < 52) return make_item(CMD_PUSH, k, rand_prio());
    if (r < 72) return make_item(CMD_POP, 0, $urandom);
    return make_item(CMD_POP, k, $urandom);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(heap_apply(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_item);
        end else if (out_item !== expected_results[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", expected_results[0], out_item);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles <= hold_off_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 1; i <= KEYS; i++) key_pos[i] = 0;
    heap_size = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed
    pending_items.push_back(make_item(CMD_POP, 0, 0));
    pending_items.push_back(make_item(CMD_POP, 5, 0));
    pending_items.push_back(make_item(CMD_POP, 300, 0));
    pending_items.push_back(make_item(CMD_PUSH, 0, 1));
    pending_items.push_back(make_item(CMD_PUSH, 511, 1));
    pending_items.push_back(make_item(CMD_PUSH, 1, 32'h7fff_ffff));
    pending_items.push_back(make_item(CMD_PUSH, 256, 32'h8000_0000));
    pending_items.push_back(make_item(CMD_PUSH, 7, 0));
    pending_items.push_back(make_item(CMD_PUSH, 8, 0));
    pending_items.push_back(make_item(CMD_PUSH, 7, 0));
    pending_items.push_back(make_item(CMD_PUSH, 256, 32'h7fff_ffff));
    pending_items.push_back(make_item(CMD_PUSH, 1, 32'hffff_ffff));
    pending_items.push_back(make_item(CMD_QUERY, 7, 0));
    pending_items.push_back(make_item(CMD_QUERY, 0, 0));
    pending_items.push_back(make_item(CMD_SPARE, 8, 5));
    pending_items.push_back(make_item(CMD_POP, 9, 0));
    pending_items.push_back(make_item(CMD_POP, 8, 0));
    pending_items.push_back(make_item(CMD_POP, 0, 0));
    pending_items.push_back(make_item(CMD_POP, 0, 0));
    pending_items.push_back(make_item(CMD_POP, 0, 0));
    pending_items.push_back(make_item(CMD_POP, 0, 0));
    wait_drained();
    // fill to capacity, then mix in random items and pop from the top
    for (int k = 1; k <= KEYS; k++) pending_items.push_back(make_item(CMD_PUSH, k, $urandom));
    pending_items.push_back(make_item(CMD_PUSH, 100, 32'h8000_0000));
    for (int k = 0; k < 20; k++) pending_items.push_back(rand_item(KEYS));
    for (int k = 0; k < 40; k++) pending_items.push_back(make_item(CMD_POP, 0, 0));
    hold_off_cycles = 3000;
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
      endcase
      for (int n = 0; n < 300; n++)
        pending_items.push_back(rand_item(ph[0] ? 16 : KEYS));
      wait_drained();
    end
    repeat (100) @(posedge clk);
    stimulus_done = 1'b1;
  end

  always @(posedge clk) begin
    if (stimulus_done) begin
      if (mismatch_count == 0 && expected_results.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
      $finish;
    end
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
src/imhq_pkg.sv
src/imhq_ram.sv
src/indexed_min_heap_queue.sv
test/tb_top.sv
